// ===== hdl/tfe_pkg.sv =====
`timescale 1ns / 1ps

package tfe_pkg;

    localparam int DATA_W            = 8;
    localparam int EXP_W             = 4;
    localparam int MAX_SIDE_EXPONENT = 15;
    localparam int COUNT_W           = 2 * MAX_SIDE_EXPONENT;
    localparam int SHIFT_W           = EXP_W + 1;
    localparam int GATHER_W          = 3 * DATA_W;
    localparam int TEXEL_W           = 4 * DATA_W;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [DATA_W-1:0] FMT_RGB888   = 8'h00;
    localparam logic [DATA_W-1:0] FMT_RGBA8888 = 8'h01;
    localparam logic [DATA_W-1:0] FMT_RGBA5551 = 8'h0f;
    localparam logic [DATA_W-1:0] FMT_RGBA4444 = 8'h10;
    localparam logic [DATA_W-1:0] FMT_RGB565   = 8'h11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_CODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_EXPONENT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_EXPONENT = 2'd2;

    typedef enum logic [2:0] {
        KIND_RGB888,
        KIND_RGBA8888,
        KIND_RGBA5551,
        KIND_RGBA4444,
        KIND_RGB565,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] bytes;  // newest byte lowest
        kind_t              kind;
        logic               last;
    } texel_t;

    typedef struct packed {
        logic [DATA_W-1:0]  format_code;
        logic [EXP_W-1:0]   width_exponent;
        logic [EXP_W-1:0]   height_exponent;
    } cfg_t;

    function automatic kind_t decode_format(input logic [DATA_W-1:0] code);
        kind_t k;
        unique case (code)
            FMT_RGB888:   k = KIND_RGB888;
            FMT_RGBA8888: k = KIND_RGBA8888;
            FMT_RGBA5551: k = KIND_RGBA5551;
            FMT_RGBA4444: k = KIND_RGBA4444;
            FMT_RGB565:   k = KIND_RGB565;
            default:      k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic logic [EXP_W-1:0] sat_exp(input logic [EXP_W-1:0] e);
        return (e > EXP_W'(MAX_SIDE_EXPONENT)) ? EXP_W'(MAX_SIDE_EXPONENT) : e;
    endfunction

    // floor(v*255/31) = 8v + floor(7v/31); the second term counts thresholds
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] adj;
        adj = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
            + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + 8'(adj);
    endfunction

    // floor(v*255/63) = 4v + floor(v/21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] adj;
        adj = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + 8'(adj);
    endfunction

    function automatic logic [7:0] expand4(input logic [3:0] v);
        return {v, v};
    endfunction

endpackage

// ===== hdl/texel_format_expander_top.sv =====
`timescale 1ns / 1ps

// Texel format expander: takes raw texture bytes one per clock and returns one
// BGRA8888 pixel per completed texel (2, 3 or 4 bytes depending on
// format_code), with last_pixel on the final pixel of a 2^(w+h) image, or one
// bad_format transaction per byte when the format code is unsupported. A
// byte is accepted in every cycle while the four-entry queue between the byte
// gatherer and the expansion/output stage has room; that queue fills only when
// m_ready stays low. A completed texel is written into the queue and its pixel
// is registered in the output stage. The user must write configuration through
// cfg_wr_en/cfg_index/cfg_wdata only while the block is idle; it is not enforced.
module texel_format_expander_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfe_pkg::DATA_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tfe_pkg::DATA_W-1:0]      s_data_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tfe_pkg::DATA_W-1:0]      m_blue,
    output logic [tfe_pkg::DATA_W-1:0]      m_green,
    output logic [tfe_pkg::DATA_W-1:0]      m_red,
    output logic [tfe_pkg::DATA_W-1:0]      m_alpha,
    output logic                            m_last_pixel,
    output logic                            m_bad_format
);

    tfe_pkg::cfg_t   cfg_reg, cfg_next;
    tfe_pkg::texel_t push_data, pop_data;
    logic            push, pop, q_empty, q_full, in_fire;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tfe_pkg::CFG_FORMAT_CODE:     cfg_next.format_code = cfg_wdata;
                tfe_pkg::CFG_WIDTH_EXPONENT:
                    cfg_next.width_exponent = cfg_wdata[tfe_pkg::EXP_W-1:0];
                tfe_pkg::CFG_HEIGHT_EXPONENT:
                    cfg_next.height_exponent = cfg_wdata[tfe_pkg::EXP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    tfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .in_byte   (s_data_byte),
        .push      (push),
        .push_data (push_data)
    );

    tfe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    tfe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .texel        (pop_data),
        .texel_avail  (!q_empty),
        .texel_pop    (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blue       (m_blue),
        .m_green      (m_green),
        .m_red        (m_red),
        .m_alpha      (m_alpha),
        .m_last_pixel (m_last_pixel),
        .m_bad_format (m_bad_format)
    );

endmodule

// ===== hdl/tfe_front.sv =====
`timescale 1ns / 1ps

module tfe_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tfe_pkg::cfg_t                 cfg,
    input  logic                          in_fire,
    input  logic [tfe_pkg::DATA_W-1:0]    in_byte,
    output logic                          push,
    output tfe_pkg::texel_t               push_data
);

    logic [tfe_pkg::GATHER_W-1:0] gathered_reg, gathered_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [tfe_pkg::COUNT_W-1:0]  count_reg, count_next;

    tfe_pkg::kind_t               kind;
    logic [2:0]                   bytes_needed;
    logic                         complete;
    logic [tfe_pkg::SHIFT_W-1:0]  shift;
    logic [tfe_pkg::COUNT_W:0]    span;
    logic [tfe_pkg::COUNT_W-1:0]  last_index;
    logic                         at_last;

    always_comb begin
        kind = tfe_pkg::decode_format(cfg.format_code);
        unique case (kind)
            tfe_pkg::KIND_RGB888:   bytes_needed = 3'd3;
            tfe_pkg::KIND_RGBA8888: bytes_needed = 3'd4;
            default:                bytes_needed = 3'd2;
        endcase
        complete = ({1'b0, phase_reg} + 3'd1) >= bytes_needed;

        shift = {1'b0, tfe_pkg::sat_exp(cfg.width_exponent)}
              + {1'b0, tfe_pkg::sat_exp(cfg.height_exponent)};
        span       = (tfe_pkg::COUNT_W+1)'(1) << shift;
        last_index = tfe_pkg::COUNT_W'(span - (tfe_pkg::COUNT_W+1)'(1));
        at_last    = count_reg >= last_index;
    end

    always_comb begin
        gathered_next   = gathered_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        push            = 1'b0;
        push_data.bytes = {gathered_reg, in_byte};
        push_data.kind  = kind;
        push_data.last  = 1'b0;
        if (in_fire) begin
            if (kind == tfe_pkg::KIND_BAD) begin
                push = 1'b1;
            end else if (!complete) begin
                gathered_next = {gathered_reg[tfe_pkg::GATHER_W-tfe_pkg::DATA_W-1:0], in_byte};
                phase_next    = phase_reg + 2'd1;
            end else begin
                push           = 1'b1;
                push_data.last = at_last;
                gathered_next  = '0;
                phase_next     = '0;
                count_next     = at_last ? '0 : count_reg + tfe_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gathered_reg <= '0;
            phase_reg    <= '0;
            count_reg    <= '0;
        end else begin
            gathered_reg <= gathered_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== hdl/tfe_queue.sv =====
`timescale 1ns / 1ps

module tfe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tfe_pkg::texel_t push_data,
    input  logic            pop,
    output tfe_pkg::texel_t pop_data,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = $clog2(tfe_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tfe_pkg::QUEUE_DEPTH + 1);

    tfe_pkg::texel_t  slots_reg [tfe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == CNT_W'(tfe_pkg::QUEUE_DEPTH);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/tfe_back.sv =====
`timescale 1ns / 1ps

module tfe_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tfe_pkg::texel_t            texel,
    input  logic                       texel_avail,
    output logic                       texel_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tfe_pkg::DATA_W-1:0] m_blue,
    output logic [tfe_pkg::DATA_W-1:0] m_green,
    output logic [tfe_pkg::DATA_W-1:0] m_red,
    output logic [tfe_pkg::DATA_W-1:0] m_alpha,
    output logic                       m_last_pixel,
    output logic                       m_bad_format
);

    logic                       valid_reg, valid_next;
    logic [tfe_pkg::DATA_W-1:0] blue_reg, green_reg, red_reg, alpha_reg;
    logic                       last_reg, bad_reg;
    logic [tfe_pkg::DATA_W-1:0] blue_next, green_next, red_next, alpha_next;
    logic                       last_next, bad_next;
    logic [15:0]                pair;
    logic [tfe_pkg::TEXEL_W-1:0] full;

    assign texel_pop = texel_avail && (!valid_reg || m_ready);

    always_comb begin
        full = texel.bytes;
        // two-byte texels are little endian: older byte is the low byte
        pair = {full[7:0], full[15:8]};
        blue_next  = '0;
        green_next = '0;
        red_next   = '0;
        alpha_next = 8'd255;
        last_next  = texel.last;
        bad_next   = 1'b0;
        unique case (texel.kind)
            tfe_pkg::KIND_RGB888: begin
                red_next   = full[23:16];
                green_next = full[15:8];
                blue_next  = full[7:0];
            end
            tfe_pkg::KIND_RGBA8888: begin
                red_next   = full[31:24];
                green_next = full[23:16];
                blue_next  = full[15:8];
                alpha_next = full[7:0];
            end
            tfe_pkg::KIND_RGBA5551: begin
                red_next   = tfe_pkg::expand5(pair[15:11]);
                green_next = tfe_pkg::expand5(pair[10:6]);
                blue_next  = tfe_pkg::expand5(pair[5:1]);
                alpha_next = pair[0] ? 8'd255 : 8'd0;
            end
            tfe_pkg::KIND_RGBA4444: begin
                red_next   = tfe_pkg::expand4(pair[15:12]);
                green_next = tfe_pkg::expand4(pair[11:8]);
                blue_next  = tfe_pkg::expand4(pair[7:4]);
                alpha_next = tfe_pkg::expand4(pair[3:0]);
            end
            tfe_pkg::KIND_RGB565: begin
                red_next   = tfe_pkg::expand5(pair[15:11]);
                green_next = tfe_pkg::expand6(pair[10:5]);
                blue_next  = tfe_pkg::expand5(pair[4:0]);
            end
            default: begin
                alpha_next = '0;
                last_next  = 1'b0;
                bad_next   = 1'b1;
            end
        endcase

        if (texel_pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (texel_pop) begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
            alpha_reg <= alpha_next;
            last_reg  <= last_next;
            bad_reg   <= bad_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_blue       = blue_reg;
    assign m_green      = green_reg;
    assign m_red        = red_reg;
    assign m_alpha      = alpha_reg;
    assign m_last_pixel = last_reg;
    assign m_bad_format = bad_reg;

endmodule

// ===== hdl/tfe_checker.sv =====
`timescale 1ns / 1ps

module tfe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tfe_pkg::DATA_W-1:0]      m_blue,
    input logic [tfe_pkg::DATA_W-1:0]      m_green,
    input logic [tfe_pkg::DATA_W-1:0]      m_red,
    input logic [tfe_pkg::DATA_W-1:0]      m_alpha,
    input logic                            m_last_pixel,
    input logic                            m_bad_format
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_blue, m_green, m_red, m_alpha,
                                                    m_last_pixel, m_bad_format}))
        else $error("m_ transaction changed while stalled");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_format |-> m_blue == '0 && m_green == '0 && m_red == '0
                                    && m_alpha == '0 && !m_last_pixel)
        else $error("bad_format transaction carries nonzero fields");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    a_accept_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_valid && s_ready |=> s_ready)
        else $error("input stalled with an empty output");

endmodule

bind texel_format_expander_top tfe_checker u_tfe_checker (.*);

// ===== verif/texel_format_expander_top_tb.sv =====
`timescale 1ns / 1ps

module texel_format_expander_top_tb;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 16;

    // unsupported codes used in the directed part
    localparam logic [tfe_pkg::DATA_W-1:0] FMT_BAD_LOW  = 8'h02;
    localparam logic [tfe_pkg::DATA_W-1:0] FMT_BAD_HIGH = 8'hFF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       last;
        logic       bad;
    } pixel_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [tfe_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [tfe_pkg::DATA_W-1:0]      cfg_wdata   = '0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    logic [tfe_pkg::DATA_W-1:0]      s_data_byte = '0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    logic [tfe_pkg::DATA_W-1:0]      m_blue;
    logic [tfe_pkg::DATA_W-1:0]      m_green;
    logic [tfe_pkg::DATA_W-1:0]      m_red;
    logic [tfe_pkg::DATA_W-1:0]      m_alpha;
    logic                            m_last_pixel;
    logic                            m_bad_format;

    texel_format_expander_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blue       (m_blue),
        .m_green      (m_green),
        .m_red        (m_red),
        .m_alpha      (m_alpha),
        .m_last_pixel (m_last_pixel),
        .m_bad_format (m_bad_format)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [tfe_pkg::DATA_W-1:0]  cur_fmt     = tfe_pkg::FMT_RGB888;
    logic [tfe_pkg::EXP_W-1:0]   cur_wexp    = '0;
    logic [tfe_pkg::EXP_W-1:0]   cur_hexp    = '0;
    logic [23:0]                 texel_bytes = '0;
    logic [1:0]                  texel_phase = '0;
    logic [tfe_pkg::COUNT_W-1:0] pixel_count = '0;

    logic [7:0] pending_bytes[$];
    pixel_t     expected_pixels[$];

    int queued_cnt     = 0;
    int accepted_cnt   = 0;
    int mismatch_cnt   = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int src_gap_left   = 0;
    int sink_stall_left = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int quiet_cycles   = 0;

    function automatic int texel_len(input logic [tfe_pkg::DATA_W-1:0] fmt);
        case (fmt)
            tfe_pkg::FMT_RGB888:   return 3;
            tfe_pkg::FMT_RGBA8888: return 4;
            tfe_pkg::FMT_RGBA5551, tfe_pkg::FMT_RGBA4444, tfe_pkg::FMT_RGB565:
                return 2;
            default:               return 0;
        endcase
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return 8'((int'(v) * 255) / 31);
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return 8'((int'(v) * 255) / 63);
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return 8'(int'(v) * 17);
    endfunction

    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // consume one byte, queue the pixel it completes (if any) or, for an unsupported format, a bad entry
    function automatic void absorb_byte(input logic [7:0] b);
        logic [31:0] full;
        logic [15:0] pair;
        logic [63:0] last_idx;
        int          n;
        int          sw;
        int          sh;
        pixel_t      px;
        px = '0;
        px.alpha = 8'hFF;
        n = texel_len(cur_fmt);
        if (n == 0) begin
            px = '0;
            px.bad = 1'b1;
            expected_pixels.push_back(px);
            return;
        end
        if (int'(texel_phase) + 1 < n) begin
            texel_bytes = {texel_bytes[15:0], b};
            texel_phase = texel_phase + 2'd1;
            return;
        end
        full = {texel_bytes, b};
        pair = {full[7:0], full[15:8]};
        case (cur_fmt)
            tfe_pkg::FMT_RGB888: begin
                px.red   = full[23:16];
                px.green = full[15:8];
                px.blue  = full[7:0];
            end
            tfe_pkg::FMT_RGBA8888: begin
                px.red   = full[31:24];
                px.green = full[23:16];
                px.blue  = full[15:8];
                px.alpha = full[7:0];
            end
            tfe_pkg::FMT_RGBA5551: begin
                px.red   = widen5(pair[15:11]);
                px.green = widen5(pair[10:6]);
                px.blue  = widen5(pair[5:1]);
                px.alpha = pair[0] ? 8'hFF : 8'h00;
            end
            tfe_pkg::FMT_RGBA4444: begin
                px.red   = widen4(pair[15:12]);
                px.green = widen4(pair[11:8]);
                px.blue  = widen4(pair[7:4]);
                px.alpha = widen4(pair[3:0]);
            end
            default: begin
                px.red   = widen5(pair[15:11]);
                px.green = widen6(pair[10:5]);
                px.blue  = widen5(pair[4:0]);
            end
        endcase
        texel_bytes = '0;
        texel_phase = '0;
        sw = (int'(cur_wexp) > tfe_pkg::MAX_SIDE_EXPONENT)
           ? tfe_pkg::MAX_SIDE_EXPONENT : int'(cur_wexp);
        sh = (int'(cur_hexp) > tfe_pkg::MAX_SIDE_EXPONENT)
           ? tfe_pkg::MAX_SIDE_EXPONENT : int'(cur_hexp);
        last_idx = (64'd1 << (sw + sh)) - 64'd1;
        if (64'(pixel_count) >= last_idx) begin
            px.last = 1'b1;
            pixel_count = '0;
        end else begin
            pixel_count = pixel_count + 1'b1;
        end
        expected_pixels.push_back(px);
    endfunction

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_byte(s_data_byte);
                accepted_cnt++;
            end
            if (s_valid && !s_ready) begin
                // hold the transaction until accepted
            end else if (src_gap_left > 0) begin
                src_gap_left--;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_valid     <= 1'b1;
                s_data_byte <= pending_bytes.pop_front();
                if ($urandom_range(0, 99) < src_gap_pct)
                    src_gap_left = pick_idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // pixel sink backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            sink_stall_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            sink_stall_left = pick_idle_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // pixel monitor
    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_blue, m_green, m_red, m_alpha, m_last_pixel, m_bad_format};
            if (expected_pixels.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected pixel: b=%0d g=%0d r=%0d a=%0d last=%0b bad=%0b",
                             got.blue, got.green, got.red, got.alpha, got.last, got.bad);
            end else begin
                want = expected_pixels.pop_front();
                if (got.blue !== want.blue || got.green !== want.green
                        || got.red !== want.red || got.alpha !== want.alpha
                        || got.last !== want.last || got.bad !== want.bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("pixel mismatch: exp b=%0d g=%0d r=%0d a=%0d last=%0b bad=%0b,",
                                 want.blue, want.green, want.red, want.alpha, want.last,
                                 want.bad,
                                 " got b=%0d g=%0d r=%0d a=%0d last=%0b bad=%0b",
                                 got.blue, got.green, got.red, got.alpha,
                                 got.last, got.bad);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [tfe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tfe_pkg::CFG_FORMAT_CODE:     cur_fmt  = val;
            tfe_pkg::CFG_WIDTH_EXPONENT:  cur_wexp = val[tfe_pkg::EXP_W-1:0];
            tfe_pkg::CFG_HEIGHT_EXPONENT: cur_hexp = val[tfe_pkg::EXP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_image(input logic [7:0] fmt, input int wexp, input int hexp);
        write_reg(tfe_pkg::CFG_FORMAT_CODE, fmt);
        write_reg(tfe_pkg::CFG_WIDTH_EXPONENT, 8'(wexp));
        write_reg(tfe_pkg::CFG_HEIGHT_EXPONENT, 8'(hexp));
    endtask

    // bytes go out most significant first
    task automatic queue_bytes(input logic [63:0] v, input int n);
        @(negedge aclk);
        for (int i = n - 1; i >= 0; i--) begin
            pending_bytes.push_back(v[8*i +: 8]);
            queued_cnt++;
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (accepted_cnt != queued_cnt || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] fmt;
        logic [7:0] fmt_list[5];
        int         wexp;
        int         hexp;
        int         n;
        int         texels;
        int         nbytes;
        fmt_list = '{tfe_pkg::FMT_RGB888, tfe_pkg::FMT_RGBA8888, tfe_pkg::FMT_RGBA5551,
                     tfe_pkg::FMT_RGBA4444, tfe_pkg::FMT_RGB565};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: each supported format with fixed byte patterns
        set_image(tfe_pkg::FMT_RGB888, 0, 0);
        queue_bytes(64'h00FF80, 3);
        drain();
        write_reg(tfe_pkg::CFG_FORMAT_CODE, tfe_pkg::FMT_RGBA8888);
        queue_bytes(64'hFF0055AA, 4);
        drain();
        write_reg(tfe_pkg::CFG_FORMAT_CODE, tfe_pkg::FMT_RGBA5551);
        queue_bytes(64'h0180FE7F, 4);
        drain();
        write_reg(tfe_pkg::CFG_FORMAT_CODE, tfe_pkg::FMT_RGBA4444);
        queue_bytes(64'h0FF0, 2);
        drain();
        write_reg(tfe_pkg::CFG_FORMAT_CODE, tfe_pkg::FMT_RGB565);
        queue_bytes(64'hFFFF, 2);
        drain();
        // unsupported codes
        write_reg(tfe_pkg::CFG_FORMAT_CODE, FMT_BAD_LOW);
        queue_bytes(64'h00, 1);
        drain();
        write_reg(tfe_pkg::CFG_FORMAT_CODE, FMT_BAD_HIGH);
        queue_bytes(64'hFF, 1);
        drain();
        // format switched with a texel half gathered
        write_reg(tfe_pkg::CFG_FORMAT_CODE, tfe_pkg::FMT_RGB888);
        queue_bytes(64'h1234, 2);
        drain();
        write_reg(tfe_pkg::CFG_FORMAT_CODE, tfe_pkg::FMT_RGB565);
        queue_bytes(64'h56, 1);
        drain();
        // image shrinks below the running pixel count
        set_image(tfe_pkg::FMT_RGB565, 1, 1);
        queue_bytes(64'h00001234, 4);
        drain();
        set_image(tfe_pkg::FMT_RGB565, 0, 0);
        queue_bytes(64'hABCD, 2);
        drain();

        // random phases
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 9) < 9) begin
                fmt = fmt_list[$urandom_range(0, 4)];
            end else begin
                do fmt = 8'($urandom_range(0, 255));
                while (texel_len(fmt) != 0);
            end
            if (ph == 1) begin
                wexp = tfe_pkg::MAX_SIDE_EXPONENT;
                hexp = tfe_pkg::MAX_SIDE_EXPONENT;
            end else if (ph == 2) begin
                wexp = 0;
                hexp = 0;
            end else begin
                wexp = ($urandom_range(0, 9) == 0) ? tfe_pkg::MAX_SIDE_EXPONENT
                                                   : $urandom_range(0, 3);
                hexp = ($urandom_range(0, 9) == 0) ? tfe_pkg::MAX_SIDE_EXPONENT
                                                   : $urandom_range(0, 3);
            end
            set_image(fmt, wexp, hexp);

            @(negedge aclk);
            if (ph % 4 == 0) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct    = $urandom_range(5, 50);
                sink_stall_pct = $urandom_range(5, 50);
            end
            if (ph == 5 || ph == 11)
                src_gap_pct = 0;

            n = texel_len(fmt);
            if (n == 0) begin
                nbytes = 40;
            end else begin
                texels = $urandom_range(30, 60);
                nbytes = texels * n;
                // leave a partial texel for the next format change
                if (ph % 3 == 1)
                    nbytes += $urandom_range(0, n - 1);
            end
            for (int i = 0; i < nbytes; i++) begin
                pending_bytes.push_back(8'($urandom_range(0, 255)));
                queued_cnt++;
            end
            if (ph == 5 || ph == 11) begin
                @(posedge aclk);
                hold_reqs <= hold_reqs + 1;
            end
            drain();
        end

        if (mismatch_cnt == 0 && expected_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
